// ----- src/olla_pkg.sv -----
// Shared constants, types and tables for the occupancy log-likelihood accumulator.
`default_nettype none

package olla_pkg;

  // Default sizes handed to the top level.
  localparam int LOGIT_WIDTH_DEF = 24;
  localparam int SUM_WIDTH_DEF   = 48;

  // Width of the shared multiplier operands and product.
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  // Width of one log term in Q16.
  localparam int TW = 25;

  // Fixed-point constants.
  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam int          X_LIMIT   = 32 * 65536;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [MW-1:0] LN2_RECIP = MW'(94548);
  localparam logic [MW-1:0] LN2_Q30 = MW'(744261118);
  localparam logic signed [TW-1:0] LOG_FLOOR = -TW'(8388608);
  localparam int TAYLOR_TERMS = 14;

  // One finished log term passed from the sequencer to the accumulator.
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic signed [TW-1:0]   term;
  } term_item_t;

  // Reciprocal ceil(2^(32+l)/k) for exact division of a 32-bit value by k.
  function automatic logic [MW-1:0] taylor_recip(input logic [3:0] k);
    logic [MW-1:0] m;
    begin
      case (k)
        4'd1:    m = MW'(64'd4294967296);
        4'd2:    m = MW'(64'd4294967296);
        4'd3:    m = MW'(64'd5726623062);
        4'd4:    m = MW'(64'd4294967296);
        4'd5:    m = MW'(64'd6871947674);
        4'd6:    m = MW'(64'd5726623062);
        4'd7:    m = MW'(64'd4908534053);
        4'd8:    m = MW'(64'd4294967296);
        4'd9:    m = MW'(64'd7635497416);
        4'd10:   m = MW'(64'd6871947674);
        4'd11:   m = MW'(64'd6247225158);
        4'd12:   m = MW'(64'd5726623062);
        4'd13:   m = MW'(64'd5286113596);
        4'd14:   m = MW'(64'd4908534053);
        default: m = MW'(64'd4294967296);
      endcase
      return m;
    end
  endfunction

  // Extra shift l = ceil(log2 k) that goes with the reciprocal above.
  function automatic logic [2:0] taylor_shift(input logic [3:0] k);
    logic [2:0] l;
    begin
      case (k)
        4'd1:    l = 3'd0;
        4'd2:    l = 3'd1;
        4'd3:    l = 3'd2;
        4'd4:    l = 3'd2;
        4'd5:    l = 3'd3;
        4'd6:    l = 3'd3;
        4'd7:    l = 3'd3;
        4'd8:    l = 3'd3;
        default: l = 3'd4;
      endcase
      return l;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/olla_if.sv -----
// Valid/ready channel interfaces for observation cells and likelihood results.
`default_nettype none

interface olla_obs_if
  import olla_pkg::*;
  #(parameter int LOGIT_WIDTH = LOGIT_WIDTH_DEF)
  ();
  logic                          valid;
  logic                          ready;
  logic signed [LOGIT_WIDTH-1:0] site_logit;
  logic signed [LOGIT_WIDTH-1:0] year_logit;
  logic signed [LOGIT_WIDTH-1:0] species_base;
  logic signed [LOGIT_WIDTH-1:0] env_slope;
  logic signed [LOGIT_WIDTH-1:0] env_value;
  logic [16:0]                   detect_prob;
  logic                          not_detected;
  logic                          may_be_absent;
  logic                          last_of_sample;

  modport source (
    output valid, site_logit, year_logit, species_base, env_slope, env_value,
           detect_prob, not_detected, may_be_absent, last_of_sample,
    input  ready
  );
  modport sink (
    input  valid, site_logit, year_logit, species_base, env_slope, env_value,
           detect_prob, not_detected, may_be_absent, last_of_sample,
    output ready
  );
endinterface

interface olla_res_if
  import olla_pkg::*;
  #(parameter int SUM_WIDTH = SUM_WIDTH_DEF)
  ();
  logic                        valid;
  logic                        ready;
  logic signed [SUM_WIDTH-1:0] log_likelihood;
  logic                        saturated;

  modport source (output valid, log_likelihood, saturated, input ready);
  modport sink (input valid, log_likelihood, saturated, output ready);
endinterface

`default_nettype wire

// ----- src/olla_mul.sv -----
// Shared signed multiplier used by the multiplying steps of the sequencer.
`default_nettype none

module olla_mul
  import olla_pkg::*;
(
  input  wire logic signed [MW-1:0] op_a,
  input  wire logic signed [MW-1:0] op_b,
  output logic signed [PW-1:0]      prod
);

  // Full-precision product; the sequencer registers what it keeps.
  assign prod = op_a * op_b;

endmodule

`default_nettype wire

// ----- src/olla_seq.sv -----
// Sequencer that turns one observation cell into one log term on a shared multiplier.
`default_nettype none

module olla_seq
  import olla_pkg::*;
#(
  parameter int LOGIT_WIDTH = LOGIT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               ready,
  input  wire logic signed [LOGIT_WIDTH-1:0] site_logit,
  input  wire logic signed [LOGIT_WIDTH-1:0] year_logit,
  input  wire logic signed [LOGIT_WIDTH-1:0] species_base,
  input  wire logic signed [LOGIT_WIDTH-1:0] env_slope,
  input  wire logic signed [LOGIT_WIDTH-1:0] env_value,
  input  wire logic [16:0]                   detect_prob,
  input  wire logic                          not_detected,
  input  wire logic                          may_be_absent,
  input  wire logic                          last_of_sample,
  output term_item_t                         item,
  input  wire logic                          take
);

  localparam int LW = LOGIT_WIDTH;
  localparam int XW = (2 * LW - 14 > 23) ? 2 * LW - 14 : 23;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOGIT = 14'b00000000000010,
    S_RANGE = 14'b00000000000100,
    S_RED   = 14'b00000000001000,
    S_RED2  = 14'b00000000010000,
    S_TMUL  = 14'b00000000100000,
    S_TDIV  = 14'b00000001000000,
    S_EXP   = 14'b00000010000000,
    S_DIV   = 14'b00000100000000,
    S_ARG   = 14'b00001000000000,
    S_NORM  = 14'b00010000000000,
    S_SQ    = 14'b00100000000000,
    S_LN    = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t st;

  logic signed [LW-1:0] site_r, year_r, base_r, slope_r, env_r;
  logic [16:0]          p_r;
  logic                 nodet_r, absent_r, last_r;
  logic signed [XW-1:0] xs;
  logic                 xneg;
  logic [21:0]          a;
  logic [5:0]           n;
  logic [15:0]          r;
  logic [32:0]          term_r;
  logic signed [35:0]   acc;
  logic [3:0]           k;
  logic [49:0]          rem, dsh;
  logic [16:0]          q;
  logic [4:0]           idx;
  logic [32:0]          w;
  logic [5:0]           m;
  logic [30:0]          mant;
  logic signed [22:0]   l2;
  logic [3:0]           i;
  logic signed [TW-1:0] term_out;

  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] mul_p;
  logic [PW-2:0]        prod_u;

  olla_mul u_mul (.op_a(op_a), .op_b(op_b), .prod(mul_p));

  assign prod_u = mul_p[PW-2:0];

  // Operand selection for the shared multiplier.
  logic [16:0] pfac;
  assign pfac = nodet_r ? (Q16_ONE - p_r) : p_r;

  always_comb begin
    case (st)
      S_LOGIT: begin
        op_a = MW'(slope_r);
        op_b = MW'(env_r);
      end
      S_RED: begin
        op_a = MW'({12'd0, a});
        op_b = LN2_RECIP;
      end
      S_TMUL: begin
        op_a = MW'(term_r);
        op_b = MW'({r, 16'd0});
      end
      S_TDIV: begin
        op_a = MW'(term_r);
        op_b = taylor_recip(k);
      end
      S_ARG: begin
        op_a = MW'(q);
        op_b = MW'(pfac);
      end
      S_SQ: begin
        op_a = MW'(mant);
        op_b = MW'(mant);
      end
      S_LN: begin
        op_a = MW'(-l2);
        op_b = LN2_Q30;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Logit sum and clamp to plus or minus 32.
  logic signed [XW-1:0] xsum, xclamp;
  always_comb begin
    xsum = xs + XW'(site_r) + XW'(year_r) + XW'(base_r);
    if (xsum > XW'(X_LIMIT)) begin
      xclamp = XW'(X_LIMIT);
    end else if (xsum < -XW'(X_LIMIT)) begin
      xclamp = -XW'(X_LIMIT);
    end else begin
      xclamp = xsum;
    end
  end

  // Range reduction remainder r = a - n*ln2 with one correction step.
  logic [21:0] nl, r0;
  assign nl = 22'(n) * 22'(LN2_Q16);
  assign r0 = a - nl;

  // Taylor division result and clamped series value.
  logic [32:0] tq;
  logic [32:0] accc, e;
  logic [33:0] d;
  logic [49:0] num;
  assign tq = 33'(prod_u >> (7'd32 + {4'd0, taylor_shift(k)}));
  always_comb begin
    if (acc < 0) begin
      accc = '0;
    end else if (acc > 36'sh100000000) begin
      accc = 33'h100000000;
    end else begin
      accc = acc[32:0];
    end
    e   = accc >> n;
    d   = 34'h100000000 + 34'(e);
    num = xneg ? {1'b0, e, 16'd0} : 50'h1000000000000;
  end

  // Log argument from psi and the detection probability.
  logic [32:0] argv;
  assign argv = prod_u[32:0] + ((nodet_r && absent_r) ? {(Q16_ONE - q), 16'd0} : 33'd0);

  logic ge;
  assign ge = rem >= dsh;

  logic [31:0] sq;
  assign sq = prod_u[61:30];

  logic signed [6:0] mexp;
  assign mexp = $signed({1'b0, m}) - 7'sd32;

  logic signed [PW-1:0] lns;
  assign lns = (PW'(1) <<< 29) - mul_p;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE:  if (start) st <= S_LOGIT;
        S_LOGIT: st <= S_RANGE;
        S_RANGE: st <= S_RED;
        S_RED:   st <= S_RED2;
        S_RED2:  st <= S_TMUL;
        S_TMUL:  st <= S_TDIV;
        S_TDIV:  st <= (k == 4'(TAYLOR_TERMS)) ? S_EXP : S_TMUL;
        S_EXP:   st <= S_DIV;
        S_DIV:   if (idx == 5'd0) st <= S_ARG;
        S_ARG:   st <= (argv == 33'd0) ? S_DONE : S_NORM;
        S_NORM:  if (w[32]) st <= S_SQ;
        S_SQ:    if (i == 4'd15) st <= S_LN;
        S_LN:    st <= S_DONE;
        S_DONE:  if (take) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        if (start) begin
          site_r   <= site_logit;
          year_r   <= year_logit;
          base_r   <= species_base;
          slope_r  <= env_slope;
          env_r    <= env_value;
          p_r      <= (detect_prob > Q16_ONE) ? Q16_ONE : detect_prob;
          nodet_r  <= not_detected;
          absent_r <= may_be_absent;
          last_r   <= last_of_sample;
        end
      end
      S_LOGIT: begin
        xs <= XW'($signed(mul_p[2*LW-1:16]));
      end
      S_RANGE: begin
        xneg <= xclamp < 0;
        a    <= (xclamp < 0) ? 22'(-xclamp) : 22'(xclamp);
      end
      S_RED: begin
        n <= mul_p[37:32];
      end
      S_RED2: begin
        if (r0 >= 22'(LN2_Q16)) begin
          n <= n + 6'd1;
          r <= 16'(r0 - 22'(LN2_Q16));
        end else begin
          r <= r0[15:0];
        end
        term_r <= 33'h100000000;
        acc    <= 36'sh100000000;
        k      <= 4'd1;
      end
      S_TMUL: begin
        term_r <= {1'b0, prod_u[63:32]};
      end
      S_TDIV: begin
        term_r <= tq;
        acc    <= k[0] ? acc - 36'(tq) : acc + 36'(tq);
        k      <= k + 4'd1;
      end
      S_EXP: begin
        rem <= num + 50'(d >> 1);
        dsh <= {d, 16'd0};
        q   <= '0;
        idx <= 5'd16;
      end
      S_DIV: begin
        if (ge) rem <= rem - dsh;
        q   <= {q[15:0], ge};
        dsh <= dsh >> 1;
        idx <= idx - 5'd1;
      end
      S_ARG: begin
        term_out <= LOG_FLOOR;
        w        <= argv;
        m        <= 6'd32;
      end
      S_NORM: begin
        if (w[32]) begin
          mant <= w[32:2];
          l2   <= {mexp[6:0], 16'd0};
          i    <= 4'd0;
        end else if (w[32:25] == 8'd0) begin
          w <= w << 8;
          m <= m - 6'd8;
        end else begin
          w <= w << 1;
          m <= m - 6'd1;
        end
      end
      S_SQ: begin
        if (sq[31]) begin
          l2   <= l2 + 23'($unsigned(16'h8000 >> i));
          mant <= sq[31:1];
        end else begin
          mant <= sq[30:0];
        end
        i <= i + 4'd1;
      end
      S_LN: begin
        term_out <= TW'(lns >>> 30);
      end
      default: ;
    endcase
  end

  assign ready      = st == S_IDLE;
  assign item.valid = st == S_DONE;
  assign item.last  = last_r;
  assign item.term  = term_out;

endmodule

`default_nettype wire

// ----- src/occupancy_log_likelihood_accumulator.sv -----
// Top level: cell channel, log-term sequencer, saturating sum and result register.
// An accepted cell's term must be computed and taken before the next cell is accepted;
// the shared multiplier, the normalize shifts and the one-bit-per-cycle psi divider set
// how long that takes, less when the log argument is zero. A held result stalls only a
// last term. The result is valid from the cycle after the last cell's term is summed.
// Reset clears the sum, the saturation flag and valids.
`default_nettype none

module occupancy_log_likelihood_accumulator
  import olla_pkg::*;
#(
  parameter int LOGIT_WIDTH = LOGIT_WIDTH_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  olla_obs_if.sink    obs,
  olla_res_if.source  res
);

  term_item_t item;
  logic       take;

  olla_seq #(.LOGIT_WIDTH(LOGIT_WIDTH)) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (obs.valid && obs.ready),
    .ready          (obs.ready),
    .site_logit     (obs.site_logit),
    .year_logit     (obs.year_logit),
    .species_base   (obs.species_base),
    .env_slope      (obs.env_slope),
    .env_value      (obs.env_value),
    .detect_prob    (obs.detect_prob),
    .not_detected   (obs.not_detected),
    .may_be_absent  (obs.may_be_absent),
    .last_of_sample (obs.last_of_sample),
    .item           (item),
    .take           (take)
  );

  logic signed [SUM_WIDTH-1:0] running_sum, sum_next;
  logic                        sum_saturated, sat_next;
  logic signed [SUM_WIDTH:0]   wide;
  logic                        res_valid;

  // A final term waits while a previous result is still held.
  assign take = item.valid && (!item.last || !res_valid || res.ready);

  // Saturating add of the new term.
  always_comb begin
    wide = {running_sum[SUM_WIDTH-1], running_sum} + (SUM_WIDTH+1)'(item.term);
    if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
      sum_next = wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                 : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      sat_next = 1'b1;
    end else begin
      sum_next = wide[SUM_WIDTH-1:0];
      sat_next = sum_saturated;
    end
  end

  // Sum state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      sum_saturated <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (take) begin
        if (item.last) begin
          running_sum   <= '0;
          sum_saturated <= 1'b0;
        end else begin
          running_sum   <= sum_next;
          sum_saturated <= sat_next;
        end
      end
      if (take && item.last) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      res.log_likelihood <= sum_next;
      res.saturated      <= sat_next;
    end
  end

  assign res.valid = res_valid;

endmodule

`default_nettype wire

// ----- test/tb_occupancy_log_likelihood_accumulator.sv -----
// Testbench for the log-likelihood accumulator: directed and random cells against a predictor.
`default_nettype none

module tb_occupancy_log_likelihood_accumulator
  import olla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW = 24;
  localparam int SW = 48;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [LW-1:0] site;
    logic signed [LW-1:0] year;
    logic signed [LW-1:0] base;
    logic signed [LW-1:0] slope;
    logic signed [LW-1:0] envv;
    logic [16:0]          prob;
    logic                 nodet;
    logic                 absent;
    logic                 last;
    logic                 known;
    logic signed [SW-1:0] want_sum;
    logic                 want_sat;
  } cell_t;

  typedef struct {
    logic signed [SW-1:0] sum;
    logic                 sat;
  } ll_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  bit drained = 1'b0;

  olla_obs_if #(.LOGIT_WIDTH(LW)) obs ();
  olla_res_if #(.SUM_WIDTH(SW)) res ();

  occupancy_log_likelihood_accumulator #(.LOGIT_WIDTH(LW), .SUM_WIDTH(SW)) dut (
    .clk(clk), .rst(rst), .obs(obs), .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state and the store of expected sample sums.
  longint pend_sum = 0;
  bit pend_sat = 1'b0;
  ll_t expected_ll[$];

  // exp(-a) in Q0.32 for a >= 0 in Q16.
  function automatic longint unsigned exp_q32(longint a);
    longint n;
    longint unsigned r, t;
    longint acc;
    n = a / 45426;
    r = longint'(a - n * 45426) << 16;
    t = 64'd1 << 32;
    acc = longint'(t);
    for (int k = 1; k <= 14; k++) begin
      t = ((t * r) >> 32) / k;
      if (k % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 32)) acc = 64'sd1 <<< 32;
    if (n >= 63) return 0;
    return longint'(acc) >> n;
  endfunction

  // Natural log of v / 2^32 in Q16.
  function automatic longint ln_q16(longint unsigned v);
    int m;
    longint unsigned mant;
    longint l2, prod;
    m = 0;
    while (m < 63 && (v >> (m + 1)) != 0) m++;
    mant = (m <= 30) ? (v << (30 - m)) : (v >> (m - 30));
    l2 = longint'(m - 32) * 65536;
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        l2 += 64'sd1 <<< (15 - i);
        mant >>= 1;
      end
    end
    prod = l2 * 744261118 + (64'sd1 <<< 29);
    return prod >>> 30;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Fold one cell into the running sum; queue the total on the last cell.
  task automatic predict_cell(input cell_t c);
    longint x, prodv, term, smax, smin;
    longint unsigned p, e, d, num, psi, arg;
    ll_t r;
    p = (c.prob > 17'd65536) ? 65536 : c.prob;
    prodv = longint'(c.slope) * longint'(c.envv);
    x = longint'(c.site) + longint'(c.year) + longint'(c.base) + (prodv >>> 16);
    if (x > X_LIMIT) x = X_LIMIT;
    if (x < -X_LIMIT) x = -X_LIMIT;
    e = exp_q32(x >= 0 ? x : -x);
    d = (64'd1 << 32) + e;
    num = (x >= 0) ? (64'd1 << 48) : (e << 16);
    psi = (num + d / 2) / d;
    if (!c.nodet) arg = psi * p;
    else if (!c.absent) arg = psi * (65536 - p);
    else arg = psi * (65536 - p) + (65536 - psi) * 65536;
    term = (arg == 0) ? -64'sd8388608 : ln_q16(arg);
    smax = (64'sd1 <<< (SW - 1)) - 1;
    smin = -smax - 1;
    if (term > 0 && pend_sum > smax - term) begin
      pend_sum = smax;
      pend_sat = 1'b1;
    end else if (term < 0 && pend_sum < smin - term) begin
      pend_sum = smin;
      pend_sat = 1'b1;
    end else begin
      pend_sum += term;
    end
    if (c.last) begin
      r.sum = pend_sum[SW-1:0];
      r.sat = pend_sat;
      if (c.known && (r.sum !== c.want_sum || r.sat !== c.want_sat))
        report_mismatch($sformatf("table row disagrees with predictor: %0d/%0b",
                                  r.sum, r.sat));
      if (c.known) begin
        r.sum = c.want_sum;
        r.sat = c.want_sat;
      end
      expected_ll.push_back(r);
      pend_sum = 0;
      pend_sat = 1'b0;
    end
  endtask

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("occupancy_log_likelihood_accumulator regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    ll_t w;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_ll.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          w = expected_ll.pop_front();
          if (res.log_likelihood !== w.sum)
            report_mismatch($sformatf("log_likelihood %0d want %0d",
                                      res.log_likelihood, w.sum));
          if (res.saturated !== w.sat)
            report_mismatch($sformatf("saturated %0b want %0b", res.saturated, w.sat));
        end
      end
      res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Source: cells handed over from a queue, with random gaps; payload driven with the valid.
  cell_t send_q[$];
  always @(posedge clk) begin
    if (rst) begin
      obs.valid <= 1'b0;
    end else begin
      if (obs.valid && obs.ready) predict_cell(send_q.pop_front());
      if (obs.valid && !obs.ready) begin
        // Hold the item and its payload.
      end else if (send_q.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
        obs.valid          <= 1'b1;
        obs.site_logit     <= send_q[0].site;
        obs.year_logit     <= send_q[0].year;
        obs.species_base   <= send_q[0].base;
        obs.env_slope      <= send_q[0].slope;
        obs.env_value      <= send_q[0].envv;
        obs.detect_prob    <= send_q[0].prob;
        obs.not_detected   <= send_q[0].nodet;
        obs.may_be_absent  <= send_q[0].absent;
        obs.last_of_sample <= send_q[0].last;
      end else begin
        obs.valid <= 1'b0;
      end
    end
  end

  function automatic cell_t mk(input int s, y, b, sl, ev, input int p,
                               input bit nd, ab, la);
    cell_t c;
    c.site = LW'(s);
    c.year = LW'(y);
    c.base = LW'(b);
    c.slope = LW'(sl);
    c.envv = LW'(ev);
    c.prob = 17'(p);
    c.nodet = nd;
    c.absent = ab;
    c.last = la;
    c.known = 1'b0;
    c.want_sum = '0;
    c.want_sat = 1'b0;
    return c;
  endfunction

  function automatic logic signed [LW-1:0] rand_logit();
    case ($urandom_range(5))
      0: return LW'($urandom);
      1: return $urandom_range(1) ? 24'sh7fffff : -24'sh800000;
      default: return LW'(int'($urandom_range(8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic cell_t rand_cell(input bit la);
    cell_t c;
    int pk;
    c = mk(0, 0, 0, 0, 0, 0, 0, 0, la);
    c.site = rand_logit();
    c.year = rand_logit();
    c.base = rand_logit();
    c.slope = rand_logit();
    c.envv = rand_logit();
    pk = $urandom_range(9);
    c.prob = (pk == 0) ? 17'd0 : (pk == 1) ? 17'd65536 :
             (pk == 2) ? 17'($urandom_range(131071, 65537)) : 17'($urandom_range(65535));
    c.nodet = 1'($urandom_range(1));
    c.absent = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic wait_drained();
    while (send_q.size() > 0 || obs.valid || expected_ll.size() > 0) @(posedge clk);
  endtask

  // Directed table; a typed expectation only where obvious.
  cell_t dir_rows[$];
  initial begin
    cell_t c;
    int n, len;
    obs.valid = 1'b0;
    res.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Detected with zero probability: log of zero floors the term.
    c = mk(0, 0, 0, 0, 0, 0, 0, 0, 1);
    c.known = 1'b1; c.want_sum = -48'sd8388608; c.want_sat = 1'b0;
    dir_rows.push_back(c);
    // Huge negative logit: psi is zero, occupied-and-missed floors too.
    c = mk(-24'sh800000, -24'sh800000, -24'sh800000, 0, 0, 32768, 1, 0, 1);
    c.known = 1'b1; c.want_sum = -48'sd8388608; c.want_sat = 1'b0;
    dir_rows.push_back(c);
    // Huge positive logit with certain detection: log of one is zero.
    c = mk(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, 0, 65536, 0, 1, 1);
    c.known = 1'b1; c.want_sum = 48'sd0; c.want_sat = 1'b0;
    dir_rows.push_back(c);
    // Detection above one is clipped to one.
    c = mk(24'sh7fffff, 0, 0, 0, 0, 131071, 0, 0, 1);
    c.known = 1'b1; c.want_sum = 48'sd0; c.want_sat = 1'b0;
    dir_rows.push_back(c);
    // Remaining flag mixes and slope extremes, checked by the predictor.
    dir_rows.push_back(mk(0, 0, 0, 24'sh7fffff, 24'sh7fffff, 40000, 1, 1, 0));
    dir_rows.push_back(mk(0, 0, 0, -24'sh800000, 24'sh7fffff, 40000, 1, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, -24'sh800000, -24'sh800000, 1, 0, 1, 1));
    dir_rows.push_back(mk(65536, -65536, 1, 0, 0, 65535, 1, 1, 1));
    dir_rows.push_back(mk(-200000, 0, 0, 0, 0, 0, 1, 1, 1));
    dir_rows.push_back(mk(300000, 0, 0, 0, 0, 65536, 1, 1, 1));
    dir_rows.push_back(mk(-1, 0, 0, 0, 0, 20000, 0, 0, 1));
    foreach (dir_rows[i]) send_q.push_back(dir_rows[i]);
    wait_drained();

    // Three idling phases; after the first the sender pauses until every result is back.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 19 : (ph == 1) ? 70 : 0;
      recv_idle = (ph == 0) ? 70 : (ph == 1) ? 19 : 0;
      n = 0;
      while (n < 530) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
        for (int j = 0; j < len; j++) send_q.push_back(rand_cell(j == len - 1));
        n += len;
        while (send_q.size() > 4) @(posedge clk);
      end
      hold_off = (ph == 0);
      while (obs.valid || expected_ll.size() > 0) @(posedge clk);
      hold_off = 1'b0;
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_ll.size() == 0 && send_q.size() == 0)
      $display("occupancy_log_likelihood_accumulator regression: pass");
    else
      $display("occupancy_log_likelihood_accumulator regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

// ----- files.f -----
src/olla_pkg.sv
src/olla_if.sv
src/olla_mul.sv
src/olla_seq.sv
src/occupancy_log_likelihood_accumulator.sv
test/tb_occupancy_log_likelihood_accumulator.sv
